@@ sv/pvszrd_pkg.sv @@
// shared types and constants for the visibility-set decoder
package pvszrd_pkg;

    localparam int COUNT_W        = 13;
    localparam int LEAF_W         = 15;
    localparam int PADDR_W        = 3;
    localparam int MAX_LEAVES_DEF = 32768;

    localparam logic [COUNT_W-1:0] BYTE_COUNT_RESET = 13'd4096;

    // register index taken from paddr[2]
    localparam logic REG_BYTE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        OP_BYTE     = 2'd0,
        OP_LEAF     = 2'd1,
        OP_OVERFLOW = 2'd2,
        OP_EMPTY    = 2'd3
    } op_t;

    localparam logic KIND_DECODE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        op_t               op;
        logic [7:0]        data_byte;
        logic [LEAF_W-1:0] leaf_index;
        logic              last_leaf;
    } item_t;

    typedef struct packed {
        logic kind;
        logic visible;
    } result_t;

    typedef struct packed {
        logic               restart;
        logic [COUNT_W-1:0] byte_count;
    } cfg_t;

endpackage

@@ sv/pvszrd_stream_if.sv @@
// valid/ready channel carrying one word of type T
interface pvszrd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/pvszrd_apb_regs.sv @@
// apb configuration register holding the decoded byte count
module pvszrd_apb_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pvszrd_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output pvszrd_pkg::cfg_t                   cfg
);
    import pvszrd_pkg::*;

    logic [COUNT_W-1:0] byte_count_reg;
    logic [COUNT_W-1:0] byte_count_next;
    logic               wr_en;
    logic               sel_count;

    // byte lanes within a register are not decoded
    assign pready    = 1'b1;
    assign sel_count = (paddr[2] == REG_BYTE_COUNT);
    assign wr_en     = psel && penable && pwrite && sel_count;

    always_comb
    begin
        byte_count_next = byte_count_reg;
        if (wr_en)
        begin
            byte_count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= BYTE_COUNT_RESET;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
        end
    end

    assign prdata         = sel_count ? {{(32-COUNT_W){1'b0}}, byte_count_reg} : 32'd0;
    assign cfg.restart    = wr_en;
    assign cfg.byte_count = byte_count_reg;

endmodule

@@ sv/pvszrd_ctrl.sv @@
// bitmap store with decode and query sequencer
module pvszrd_ctrl #(
    parameter int MAX_LEAVES = pvszrd_pkg::MAX_LEAVES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pvszrd_pkg::cfg_t      cfg,
    pvszrd_stream_if.sink         item,
    pvszrd_stream_if.source       result
);
    import pvszrd_pkg::*;

    localparam int BYTES  = (MAX_LEAVES + 7) / 8;
    localparam int ADDR_W = (BYTES > 1) ? $clog2(BYTES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BYTES - 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_QUERY = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t             state_reg,     state_next;
    logic [COUNT_W-1:0] wp_reg,        wp_next;
    logic               expect_reg,    expect_next;
    logic               hit_reg,       hit_next;
    logic [7:0]         run_cnt_reg,   run_cnt_next;
    logic               q_ok_reg,      q_ok_next;
    logic [2:0]         q_sel_reg,     q_sel_next;
    logic               q_last_reg,    q_last_next;
    result_t            emit_reg,      emit_next;
    logic [ADDR_W-1:0]  clr_addr_reg,  clr_addr_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg,  out_data_next;

    logic [7:0]         mem [BYTES];
    logic [7:0]         rdata_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [7:0]         mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;

    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] wp_inc;
    logic               at_end;
    logic               accept;
    logic               leaf_in_map;
    logic               hit_now;
    item_t              it;

    assign it = item.data;

    // effective map length: zero acts as one, clipped to the store size
    always_comb
    begin
        if (cfg.byte_count == '0)
        begin
            limit = COUNT_W'(1);
        end
        else if ({1'b0, cfg.byte_count} > (COUNT_W+1)'(BYTES))
        begin
            limit = COUNT_W'(BYTES);
        end
        else
        begin
            limit = cfg.byte_count;
        end
    end

    assign wp_inc      = wp_reg + COUNT_W'(1);
    assign at_end      = (wp_inc >= limit);
    assign item.ready  = (state_reg == ST_IDLE);
    assign accept      = item.valid && item.ready;
    assign leaf_in_map = ({2'b00, it.leaf_index} < (LEAF_W+2)'(MAX_LEAVES));
    assign hit_now     = hit_reg || (q_ok_reg && rdata_reg[q_sel_reg]);

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        expect_next    = expect_reg;
        hit_next       = hit_reg;
        run_cnt_next   = run_cnt_reg;
        q_ok_next      = q_ok_reg;
        q_sel_next     = q_sel_reg;
        q_last_next    = q_last_reg;
        emit_next      = emit_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = ADDR_W'(wp_reg);
        mem_wdata      = 8'd0;
        mem_raddr      = ADDR_W'(it.leaf_index[LEAF_W-1:3]);

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (it.op)
                        OP_BYTE:
                        begin
                            if (expect_reg)
                            begin
                                expect_next  = 1'b0;
                                run_cnt_next = it.data_byte;
                                if (it.data_byte != 8'd0)
                                begin
                                    state_next = ST_RUN;
                                end
                            end
                            else if (it.data_byte == 8'd0)
                            begin
                                expect_next = 1'b1;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = it.data_byte;
                                if (at_end)
                                begin
                                    wp_next    = '0;
                                    emit_next  = '{kind: KIND_DECODE, visible: 1'b0};
                                    state_next = ST_EMIT;
                                end
                                else
                                begin
                                    wp_next = wp_inc;
                                end
                            end
                        end
                        OP_LEAF:
                        begin
                            q_ok_next   = leaf_in_map;
                            q_sel_next  = it.leaf_index[2:0];
                            q_last_next = it.last_leaf;
                            state_next  = ST_QUERY;
                        end
                        OP_OVERFLOW,
                        OP_EMPTY:
                        begin
                            hit_next   = 1'b0;
                            emit_next  = '{kind: KIND_QUERY, visible: (it.op == OP_OVERFLOW)};
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // one zero byte per cycle, stops at the count or at the map end
                mem_we       = 1'b1;
                run_cnt_next = run_cnt_reg - 8'd1;
                if (at_end)
                begin
                    wp_next    = '0;
                    emit_next  = '{kind: KIND_DECODE, visible: 1'b0};
                    state_next = ST_EMIT;
                end
                else
                begin
                    wp_next = wp_inc;
                    if (run_cnt_reg == 8'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_QUERY:
            begin
                if (q_last_reg)
                begin
                    hit_next   = 1'b0;
                    emit_next  = '{kind: KIND_QUERY, visible: hit_now};
                    state_next = ST_EMIT;
                end
                else
                begin
                    hit_next   = hit_now;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = emit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register write restarts the map, bitmap kept
        if (cfg.restart)
        begin
            wp_next     = '0;
            expect_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            wp_reg        <= '0;
            expect_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            run_cnt_reg   <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            expect_reg    <= expect_next;
            hit_reg       <= hit_next;
            run_cnt_reg   <= run_cnt_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_ok_reg     <= q_ok_next;
        q_sel_reg    <= q_sel_next;
        q_last_reg   <= q_last_next;
        emit_reg     <= emit_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    a_wp_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg < limit)
        else $error("write pointer beyond map end");

    a_run_no_expect: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !expect_reg)
        else $error("run active while still expecting a count");

    a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(state_reg == ST_CLEAR) |-> $past(clr_addr_reg == LAST_ADDR))
        else $error("clearing pass ended early");

    a_hit_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hit_reg) |-> $past(state_reg == ST_QUERY))
        else $error("query hit set outside a leaf test");

endmodule

@@ sv/pvs_zero_run_decode_and_visibility.sv @@
// Zero-run visibility-set decoder with leaf query. After reset the bitmap store is
// cleared by a pass over its (MAX_LEAVES+7)/8 bytes (4096 at the default) during which no
// word is accepted; configuration writes are taken at any time. The store is a single
// memory with one write and one registered read port, so every word is handled in
// turn: a literal byte is written, and completing the map also emits a result; the zero
// marker only arms the count; a run count writes one zero byte a cycle up to the count
// or the map end, then emits a result when the map completes; a listed leaf waits for
// the memory read, and the one closing the list emits the answer; an overflow or
// empty-list query emits its answer with no memory read. A result word waits in an
// output register while the next word is accepted.
module pvs_zero_run_decode_and_visibility #(
    parameter int MAX_LEAVES = pvszrd_pkg::MAX_LEAVES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pvszrd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    pvszrd_stream_if.sink                  item,
    pvszrd_stream_if.source                result
);
    import pvszrd_pkg::*;

    cfg_t cfg;

    pvszrd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pvszrd_ctrl #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );

endmodule

@@ tb/sv/pvs_zero_run_decode_and_visibility_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the visibility-set decoder and leaf query
module pvs_zero_run_decode_and_visibility_test;
    import pvszrd_pkg::*;

    localparam int MAP_BYTES     = (MAX_LEAVES_DEF + 7) / 8;
    localparam int SETTLE_CYCLES = 300;
    localparam int LONG_STALL    = 600;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int PHASES        = 11;
    localparam int PHASE_WORDS   = 150;
    localparam logic [PADDR_W-1:0] BYTE_COUNT_ADDR = {REG_BYTE_COUNT, 2'b00};

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    pvszrd_stream_if #(.T(item_t))   item_ch ();
    pvszrd_stream_if #(.T(result_t)) result_ch ();

    pvs_zero_run_decode_and_visibility #(
        .MAX_LEAVES (MAX_LEAVES_DEF)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    // shadow of the decoder state
    logic [7:0]         shadow_map [MAP_BYTES];
    int unsigned        fill_pos;
    bit                 count_due;
    bit                 list_seen;
    logic [COUNT_W-1:0] set_bytes;

    item_t   stream_words[$];
    result_t awaited_results[$];

    int error_count     = 0;
    int words_sent      = 0;
    int results_seen    = 0;
    int maps_done       = 0;
    int answers_seen    = 0;
    int cycle_count     = 0;
    int sizes_tried     = 0;
    int phase_words     = 0;
    int idle_pct        = 34;
    int stall_left      = 0;
    bit long_stall_done = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    task report_mismatch(input string what);
        if (error_count < 50)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function int unsigned active_bytes();
        int unsigned n;
        n = 32'(set_bytes);
        if (n == 0)
            n = 1;
        if (n > MAP_BYTES)
            n = MAP_BYTES;
        return n;
    endfunction

    task decode_and_answer(input item_t w);
        int unsigned lim;
        int unsigned n;
        logic        hit;
        result_t     r;
        case (w.op)
            OP_BYTE:
            begin
                lim = active_bytes();
                if (fill_pos >= lim)
                    fill_pos = 0;
                if (count_due)
                begin
                    // zero run, clipped at the end of the map
                    n = (32'(w.data_byte) < lim - fill_pos) ?
                        32'(w.data_byte) : lim - fill_pos;
                    count_due = 1'b0;
                    repeat (n)
                    begin
                        shadow_map[fill_pos] = 8'h00;
                        fill_pos++;
                    end
                end
                else if (w.data_byte == 8'h00)
                    count_due = 1'b1;
                else
                begin
                    shadow_map[fill_pos] = w.data_byte;
                    fill_pos++;
                end
                if (fill_pos >= lim)
                begin
                    fill_pos  = 0;
                    count_due = 1'b0;
                    r.kind    = KIND_DECODE;
                    r.visible = 1'b0;
                    awaited_results.push_back(r);
                end
            end
            OP_LEAF:
            begin
                hit = list_seen;
                if (w.leaf_index < MAX_LEAVES_DEF)
                    hit = hit | shadow_map[w.leaf_index >> 3][w.leaf_index[2:0]];
                if (!w.last_leaf)
                    list_seen = hit;
                else
                begin
                    list_seen = 1'b0;
                    r.kind    = KIND_QUERY;
                    r.visible = hit;
                    awaited_results.push_back(r);
                end
            end
            default:
            begin
                // overflow answers visible, empty list not; a partial list is dropped
                list_seen = 1'b0;
                r.kind    = KIND_QUERY;
                r.visible = (w.op == OP_OVERFLOW);
                awaited_results.push_back(r);
            end
        endcase
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                decode_and_answer(item_ch.data);
                words_sent++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (stream_words.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    item_ch.valid <= 1'b1;
                    item_ch.data  <= stream_words.pop_front();
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off while words are still queued
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else if (!long_stall_done && results_seen >= 80 && stream_words.size() > 40)
        begin
            long_stall_done <= 1'b1;
            stall_left      <= LONG_STALL;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin : watch_results
        result_t want;
        result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            results_seen++;
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("unexpected word kind %0d visible %0d",
                                          got.kind, got.visible));
            else
            begin
                want = awaited_results.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
                else if (got.visible !== want.visible)
                    report_mismatch($sformatf("visible %0d, expected %0d (kind %0d)",
                                              got.visible, want.visible, want.kind));
                if (want.kind == KIND_DECODE)
                    maps_done++;
                else
                    answers_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    task queue_word(input op_t op, input logic [7:0] b, input logic [LEAF_W-1:0] leaf,
                    input logic last);
        item_t w;
        w.op         = op;
        w.data_byte  = b;
        w.leaf_index = leaf;
        w.last_leaf  = last;
        stream_words.push_back(w);
        phase_words++;
    endtask

    task wait_drained();
        while (stream_words.size() != 0 || item_ch.valid || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // a word without a result may still be in work after the last result
    task settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task set_map_size(input logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BYTE_COUNT_ADDR;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        set_bytes = v[COUNT_W-1:0];
        fill_pos  = 0;
        count_due = 1'b0;
        sizes_tried++;
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[COUNT_W-1:0] !== set_bytes)
            report_mismatch($sformatf("byte count reads %0d, written %0d",
                                      prdata[COUNT_W-1:0], set_bytes));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task queue_list(input int unsigned lim);
        int          len;
        logic [14:0] leaf;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) < 7)
                leaf = 15'($urandom_range(lim * 8 - 1));
            else
                leaf = 15'($urandom_range(32767));
            if (i == len - 1 && $urandom_range(9) == 0)
                queue_word(op_t'($urandom_range(2, 3)), 8'($urandom), LEAF_W'($urandom),
                           1'($urandom));
            else
                queue_word(OP_LEAF, 8'($urandom), leaf, i == len - 1);
        end
    endtask

    // well-formed compressed set of lim bytes, with queries mixed in
    task queue_map(input int unsigned lim);
        int unsigned left;
        int unsigned run;
        int          pick;
        left = lim;
        while (left != 0)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                queue_list(lim);
            else if (pick < 45)
            begin
                run = $urandom_range(1, (left < 255) ? left : 255);
                if (pick < 12)
                    run = 0;
                else if (pick < 16)
                    run = $urandom_range(run, 255);
                queue_word(OP_BYTE, 8'h00, LEAF_W'($urandom), 1'($urandom));
                queue_word(OP_BYTE, run[7:0], LEAF_W'($urandom), 1'($urandom));
                left -= (run < left) ? run : left;
            end
            else
            begin
                queue_word(OP_BYTE, 8'($urandom_range(1, 255)), LEAF_W'($urandom),
                           1'($urandom));
                left--;
            end
        end
    endtask

    initial
    begin : stimulus
        int          sel;
        int          pick;
        bit          paused;
        logic [31:0] size;
        foreach (shadow_map[i])
            shadow_map[i] = 8'h00;
        fill_pos  = 0;
        count_due = 1'b0;
        list_seen = 1'b0;
        set_bytes = BYTE_COUNT_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // cleared store, literal bytes, lists, overflow and empty answers
        queue_word(OP_LEAF, 8'h00, 15'd0, 1'b1);
        queue_word(OP_OVERFLOW, 8'h00, 15'd0, 1'b0);
        queue_word(OP_EMPTY, 8'h00, 15'd0, 1'b0);
        queue_word(OP_BYTE, 8'hff, 15'd0, 1'b0);
        queue_word(OP_BYTE, 8'h01, 15'd0, 1'b0);
        queue_word(OP_BYTE, 8'h80, 15'd0, 1'b0);
        queue_word(OP_LEAF, 8'h00, 15'd7, 1'b0);
        queue_word(OP_LEAF, 8'h00, 15'd32767, 1'b1);
        queue_word(OP_LEAF, 8'h00, 15'd32767, 1'b1);
        queue_word(OP_LEAF, 8'h00, 15'd9, 1'b0);
        queue_word(OP_OVERFLOW, 8'h00, 15'd0, 1'b0);
        queue_word(OP_LEAF, 8'h00, 15'd8, 1'b0);
        queue_word(OP_EMPTY, 8'h00, 15'd0, 1'b0);
        queue_word(OP_LEAF, 8'h00, 15'd10, 1'b1);
        // zero count, then a query between marker and count
        queue_word(OP_BYTE, 8'h00, 15'd0, 1'b0);
        queue_word(OP_BYTE, 8'h00, 15'd0, 1'b0);
        queue_word(OP_BYTE, 8'h00, 15'd0, 1'b0);
        queue_word(OP_LEAF, 8'h00, 15'd23, 1'b1);
        queue_word(OP_BYTE, 8'hff, 15'd0, 1'b0);
        queue_word(OP_BYTE, 8'h7f, 15'd0, 1'b0);
        queue_word(OP_LEAF, 8'h00, 15'd2064, 1'b1);
        queue_word(OP_LEAF, 8'h00, 15'd2071, 1'b1);
        settle();

        // oversized count acts as the full store; store kept over the write
        set_map_size(32'd8191);
        queue_word(OP_LEAF, 8'h00, 15'd0, 1'b1);
        repeat (17)
        begin
            queue_word(OP_BYTE, 8'h00, 15'd0, 1'b0);
            queue_word(OP_BYTE, 8'hff, 15'd0, 1'b0);
        end
        queue_word(OP_LEAF, 8'h00, 15'd0, 1'b1);
        queue_word(OP_BYTE, 8'haa, 15'd0, 1'b0);
        queue_word(OP_LEAF, 8'h00, 15'd1, 1'b1);
        settle();

        // zero count acts as one byte; run clipped at the end
        set_map_size(32'd0);
        queue_word(OP_BYTE, 8'h5a, 15'd0, 1'b0);
        queue_word(OP_BYTE, 8'h00, 15'd0, 1'b0);
        queue_word(OP_BYTE, 8'h09, 15'd0, 1'b0);
        queue_word(OP_LEAF, 8'h00, 15'd1, 1'b1);
        queue_word(OP_LEAF, 8'h00, 15'd3, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            sel = $urandom_range(99);
            if (p == 0)
                size = 1;
            else if (p == 1)
                size = 4096;
            else if (p == 2)
                size = 3;
            else if (sel < 40)
                size = $urandom_range(1, 8);
            else if (sel < 80)
                size = $urandom_range(9, 64);
            else if (sel < 92)
                size = $urandom_range(65, 600);
            else if (sel < 96)
                size = 4096;
            else
                size = $urandom_range(4097, 8191);
            set_map_size(size);
            idle_pct    = (p == 4) ? 0 : 34;
            phase_words = 0;
            paused      = 1'b0;
            while (phase_words < PHASE_WORDS)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    queue_map(active_bytes());
                else if (pick < 85)
                    queue_list(active_bytes());
                else
                    queue_word(op_t'($urandom_range(3)), 8'($urandom), LEAF_W'($urandom),
                               1'($urandom));
                // halfway through the phase, queuing pauses until every answer is in
                if (!paused && phase_words >= PHASE_WORDS / 2)
                begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
        end
        settle();

        $display("decoded and queried %0d words under %0d byte-count settings",
                 words_sent, sizes_tried);
        $display("compared %0d completed maps and %0d query answers", maps_done, answers_seen);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
sv/pvszrd_pkg.sv
sv/pvszrd_stream_if.sv
sv/pvszrd_apb_regs.sv
sv/pvszrd_ctrl.sv
sv/pvs_zero_run_decode_and_visibility.sv
tb/sv/pvs_zero_run_decode_and_visibility_test.sv
